// ===== sv/four_class_stable_priority_queue_defines.svh =====
`ifndef FOUR_CLASS_STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define FOUR_CLASS_STABLE_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FCSPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define FCSPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/fcspq_pkg.sv =====
package fcspq_pkg;

   localparam int TAG_FIELD_W = 16;
   localparam int URG_W       = 2;
   localparam int NUM_CLASSES = 4;
   localparam int POS_W       = 4;
   localparam int OCC_W       = 5;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_SERVE_ONE = 2'd1,
      OP_SERVE_ALL = 2'd2,
      OP_LIST      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_GIVEN    = 2'd0,
      STATUS_ACCEPTED = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type     cmd;
      logic [URG_W-1:0] urgency;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_DRAIN = 2'd1,
      S_SCAN  = 2'd2
   } state_type;

endpackage

// ===== sv/fcspq_cell.sv =====
module fcspq_cell import fcspq_pkg::*; #(
   parameter int TAG_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [TAG_W-1:0] new_tag,
   input  logic [URG_W-1:0] head_urgency,
   input  logic [TAG_W-1:0] head_tag,
   input  logic             left_ins,
   input  logic             left_valid,
   input  logic [URG_W-1:0] left_urgency,
   input  logic [TAG_W-1:0] left_tag,
   input  logic             right_valid,
   input  logic [URG_W-1:0] right_urgency,
   input  logic [TAG_W-1:0] right_tag,
   output logic             valid,
   output logic [URG_W-1:0] urgency,
   output logic [TAG_W-1:0] tag,
   output logic             ins
);

   logic             valid_ff, valid_in;
   logic [URG_W-1:0] urgency_ff, urgency_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // this slot and everything after it moves right on an insert
   assign ins = !valid_ff || (urgency_ff > ctl.urgency);

   always_comb begin
      valid_in   = valid_ff;
      urgency_in = urgency_ff;
      tag_in     = tag_ff;
      unique case (ctl.cmd)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (ins) begin
               if (left_ins) begin
                  valid_in   = left_valid;
                  urgency_in = left_urgency;
                  tag_in     = left_tag;
               end else begin
                  valid_in   = 1'b1;
                  urgency_in = ctl.urgency;
                  tag_in     = new_tag;
               end
            end
         end
         CELL_SHIFT: begin
            valid_in   = right_valid;
            urgency_in = right_urgency;
            tag_in     = right_tag;
         end
         CELL_ROTATE: begin
            // last occupied slot takes the head, the rest advance
            if (valid_ff && !right_valid) begin
               urgency_in = head_urgency;
               tag_in     = head_tag;
            end else begin
               valid_in   = right_valid;
               urgency_in = right_urgency;
               tag_in     = right_tag;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      urgency_ff <= urgency_in;
      tag_ff     <= tag_in;
   end

   assign valid   = valid_ff;
   assign urgency = urgency_ff;
   assign tag     = tag_ff;

endmodule

// ===== sv/four_class_stable_priority_queue.sv =====
// channel    ports                                    handshake
// request    req_op, req_urgency, req_tag             start high, busy low
// response   rsp_status, rsp_out_tag, rsp_out_urgency, rsp_valid for one cycle
//            rsp_position, rsp_occupancy, rsp_last
//
// Insert and serve one requests, and requests on an empty queue, leave busy
// low; the response shows in the cycle after the request, so requests may come back to back.
// Serve all and list give one response per entry held: the cell chain shifts or
// rotates once per response, and busy is high until the last one goes out.
// Reset clears the cell valid bits, the class counters and the entry count.
// The receiver cannot stall; every response is shown for exactly one cycle.
`include "four_class_stable_priority_queue_defines.svh"

module four_class_stable_priority_queue import fcspq_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int TAG_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_op,
   input  logic [URG_W-1:0]       req_urgency,
   input  logic [TAG_FIELD_W-1:0] req_tag,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [TAG_FIELD_W-1:0] rsp_out_tag,
   output logic [URG_W-1:0]       rsp_out_urgency,
   output logic [POS_W-1:0]       rsp_position,
   output logic [OCC_W-1:0]       rsp_occupancy,
   output logic                   rsp_last
);

   localparam int TAG_W = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
   localparam int CW    = $clog2(CAPACITY + 1);

   // chain wires; slot CAPACITY is the empty neighbor right of the last cell
   logic             valid_w   [0:CAPACITY];
   logic [URG_W-1:0] urgency_w [0:CAPACITY];
   logic [TAG_W-1:0] tag_w     [0:CAPACITY];
   logic             ins_w     [0:CAPACITY-1];

   cell_ctl_type     cell_ctl;
   logic [TAG_W-1:0] new_tag;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [CW-1:0]    class_cnt_ff [NUM_CLASSES];
   logic [CW-1:0]    class_cnt_in [NUM_CLASSES];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [TAG_FIELD_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [URG_W-1:0]       rsp_urgency_ff, rsp_urgency_in;
   logic [POS_W-1:0]       rsp_position_ff, rsp_position_in;
   logic [OCC_W-1:0]       rsp_occupancy_ff, rsp_occupancy_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [CW-1:0]   slot;
   logic            do_insert;
   logic            do_pop;
   logic            full;
   logic            empty;
   logic [CW+1:0]   class_total;

   assign new_tag = req_tag[TAG_W-1:0];
   assign valid_w[CAPACITY]   = 1'b0;
   assign urgency_w[CAPACITY] = '0;
   assign tag_w[CAPACITY]     = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         fcspq_cell #(.TAG_W(TAG_W)) u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctl           (cell_ctl),
            .new_tag       (new_tag),
            .head_urgency  (urgency_w[0]),
            .head_tag      (tag_w[0]),
            .left_ins      (1'b0),
            .left_valid    (1'b0),
            .left_urgency  ('0),
            .left_tag      ('0),
            .right_valid   (valid_w[i+1]),
            .right_urgency (urgency_w[i+1]),
            .right_tag     (tag_w[i+1]),
            .valid         (valid_w[i]),
            .urgency       (urgency_w[i]),
            .tag           (tag_w[i]),
            .ins           (ins_w[i])
         );
      end else begin : g_body
         fcspq_cell #(.TAG_W(TAG_W)) u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctl           (cell_ctl),
            .new_tag       (new_tag),
            .head_urgency  (urgency_w[0]),
            .head_tag      (tag_w[0]),
            .left_ins      (ins_w[i-1]),
            .left_valid    (valid_w[i-1]),
            .left_urgency  (urgency_w[i-1]),
            .left_tag      (tag_w[i-1]),
            .right_valid   (valid_w[i+1]),
            .right_urgency (urgency_w[i+1]),
            .right_tag     (tag_w[i+1]),
            .valid         (valid_w[i]),
            .urgency       (urgency_w[i]),
            .tag           (tag_w[i]),
            .ins           (ins_w[i])
         );
      end
   end

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);
   assign busy  = (state_ff != S_IDLE);

   // insert slot: entries of equal or higher urgency stay ahead
   always_comb begin
      slot = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (URG_W'(c) <= req_urgency) begin
            slot = slot + class_cnt_ff[c];
         end
      end
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      k_in             = k_ff;
      do_insert        = 1'b0;
      do_pop           = 1'b0;
      cell_ctl.cmd     = CELL_HOLD;
      cell_ctl.urgency = req_urgency;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_tag_in       = rsp_tag_ff;
      rsp_urgency_in   = rsp_urgency_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      rsp_last_in      = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (op_type'(req_op) == OP_INSERT) begin
                  if (full) begin
                     rsp_status_in    = STATUS_FULL;
                     rsp_tag_in       = '0;
                     rsp_urgency_in   = '0;
                     rsp_position_in  = '0;
                     rsp_occupancy_in = OCC_W'(count_ff);
                  end else begin
                     do_insert        = 1'b1;
                     cell_ctl.cmd     = CELL_INSERT;
                     count_in         = count_ff + 1'b1;
                     rsp_status_in    = STATUS_ACCEPTED;
                     rsp_tag_in       = TAG_FIELD_W'(new_tag);
                     rsp_urgency_in   = req_urgency;
                     rsp_position_in  = POS_W'(slot);
                     rsp_occupancy_in = OCC_W'(count_in);
                  end
               end else if (empty) begin
                  rsp_status_in    = STATUS_EMPTY;
                  rsp_tag_in       = '0;
                  rsp_urgency_in   = '0;
                  rsp_position_in  = '0;
                  rsp_occupancy_in = '0;
               end else begin
                  rsp_status_in   = STATUS_GIVEN;
                  rsp_tag_in      = TAG_FIELD_W'(tag_w[0]);
                  rsp_urgency_in  = urgency_w[0];
                  rsp_position_in = '0;
                  k_in            = CW'(1);
                  if (op_type'(req_op) == OP_LIST) begin
                     cell_ctl.cmd     = CELL_ROTATE;
                     rsp_occupancy_in = OCC_W'(count_ff);
                     rsp_last_in      = (count_ff == CW'(1));
                     if (!rsp_last_in) begin
                        state_in = S_SCAN;
                     end
                  end else begin
                     do_pop           = 1'b1;
                     cell_ctl.cmd     = CELL_SHIFT;
                     count_in         = count_ff - 1'b1;
                     rsp_occupancy_in = OCC_W'(count_in);
                     if (op_type'(req_op) == OP_SERVE_ALL && count_ff != CW'(1)) begin
                        rsp_last_in = 1'b0;
                        state_in    = S_DRAIN;
                     end
                  end
               end
            end
         end
         S_DRAIN: begin
            do_pop           = 1'b1;
            cell_ctl.cmd     = CELL_SHIFT;
            count_in         = count_ff - 1'b1;
            k_in             = k_ff + 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_status_in    = STATUS_GIVEN;
            rsp_tag_in       = TAG_FIELD_W'(tag_w[0]);
            rsp_urgency_in   = urgency_w[0];
            rsp_position_in  = POS_W'(k_ff);
            rsp_occupancy_in = OCC_W'(count_in);
            rsp_last_in      = (count_ff == CW'(1));
            if (rsp_last_in) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cell_ctl.cmd     = CELL_ROTATE;
            k_in             = k_ff + 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_status_in    = STATUS_GIVEN;
            rsp_tag_in       = TAG_FIELD_W'(tag_w[0]);
            rsp_urgency_in   = urgency_w[0];
            rsp_position_in  = POS_W'(k_ff);
            rsp_occupancy_in = OCC_W'(count_ff);
            rsp_last_in      = (k_in == count_ff);
            if (rsp_last_in) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // per-class occupancy feeds the insert slot
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         class_cnt_in[c] = class_cnt_ff[c];
         if (do_insert && req_urgency == URG_W'(c)) begin
            class_cnt_in[c] = class_cnt_ff[c] + 1'b1;
         end
         if (do_pop && urgency_w[0] == URG_W'(c)) begin
            class_cnt_in[c] = class_cnt_ff[c] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            class_cnt_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            class_cnt_ff[c] <= class_cnt_in[c];
         end
      end
      rsp_status_ff    <= rsp_status_in;
      rsp_tag_ff       <= rsp_tag_in;
      rsp_urgency_ff   <= rsp_urgency_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_out_urgency = rsp_urgency_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_occupancy   = rsp_occupancy_ff;
   assign rsp_last        = rsp_last_ff;

   assign class_total = (CW+2)'(class_cnt_ff[0]) + (CW+2)'(class_cnt_ff[1])
                      + (CW+2)'(class_cnt_ff[2]) + (CW+2)'(class_cnt_ff[3]);

   `FCSPQ_ASSERT_NOW(a_class_sum, clock, reset, 1'b1,
      class_total == (CW+2)'(count_ff), "class counters disagree with entry count")
   `FCSPQ_ASSERT_NOW(a_head_valid, clock, reset, 1'b1,
      valid_w[0] == (count_ff != '0), "head cell valid disagrees with entry count")
   `FCSPQ_ASSERT_NEXT(a_drain_end, clock, reset, state_ff == S_DRAIN && count_ff == CW'(1),
      state_ff == S_IDLE && count_ff == '0, "drain did not end empty")
   `FCSPQ_ASSERT_NEXT(a_req_rsp, clock, reset, start && !busy,
      rsp_valid, "accepted request gave no response")

endmodule
